[rtl/core/nrm_pkg.sv]
`timescale 1ns / 1ps
package nrm_pkg;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_SPLIT = 2'd1;

    localparam logic [7:0] EMPTY_CHAR = 8'd0;

    localparam logic REG_START  = 1'b0;
    localparam logic REG_ACCEPT = 1'b1;

    typedef struct packed {
        logic clear;
        logic load;
        logic step;
        logic close;
    } cell_cmd_t;

endpackage

[rtl/core/nrm_cell.sv]
`timescale 1ns / 1ps
module nrm_cell #(
    parameter int NUM_STATES = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en,
    input  logic [1:0]             wr_kind,
    input  logic [7:0]             wr_char,
    input  logic [6:0]             wr_first,
    input  logic [6:0]             wr_second,
    input  nrm_pkg::cell_cmd_t     cmd,
    input  logic                   is_start,
    input  logic                   eps_hit,
    input  logic                   step_hit,
    input  logic [7:0]             text_byte,
    output logic                   active,
    output logic [NUM_STATES-1:0]  eps_vec,
    output logic [NUM_STATES-1:0]  step_vec
);

    logic [1:0] kind_reg;
    logic [7:0] char_reg;
    logic [6:0] first_reg;
    logic [6:0] second_reg;
    logic       active_reg;

    logic [NUM_STATES-1:0] first_hot;
    logic [NUM_STATES-1:0] second_hot;
    logic                  is_char;
    logic                  is_empty;

    localparam logic [NUM_STATES-1:0] ONE = {{(NUM_STATES-1){1'b0}}, 1'b1};

    always_comb begin
        first_hot  = (!first_reg[6] && (32'(first_reg) < NUM_STATES))
                     ? (ONE << first_reg[5:0]) : '0;
        second_hot = (!second_reg[6] && (32'(second_reg) < NUM_STATES))
                     ? (ONE << second_reg[5:0]) : '0;
        is_char    = (kind_reg == nrm_pkg::KIND_CHAR);
        is_empty   = (char_reg == nrm_pkg::EMPTY_CHAR);
        eps_vec    = '0;
        step_vec   = '0;
        if (active_reg) begin
            if (kind_reg == nrm_pkg::KIND_SPLIT) begin
                eps_vec = first_hot | second_hot;
            end else if (is_char && is_empty) begin
                eps_vec = first_hot;
            end
            if (is_char && !is_empty && (char_reg == text_byte)) begin
                step_vec = first_hot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            kind_reg   <= wr_kind;
            char_reg   <= wr_char;
            first_reg  <= wr_first;
            second_reg <= wr_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (cmd.clear) begin
            active_reg <= 1'b0;
        end else if (cmd.load) begin
            active_reg <= is_start;
        end else if (cmd.step) begin
            active_reg <= step_hit;
        end else if (cmd.close) begin
            active_reg <= active_reg | eps_hit;
        end
    end

    assign active = active_reg;

endmodule

[rtl/core/nfa_regex_matcher.sv]
`timescale 1ns / 1ps
// Channel | Direction | Ports
// s_      | in        | s_valid s_ready s_mode s_entry_index s_entry_kind s_entry_char
//         |           | s_entry_first_next s_entry_second_next s_text_byte
// m_      | out       | m_valid m_ready m_verdict_valid m_matched m_alive
// cfg_    | in        | cfg_wr_en cfg_addr cfg_wdata
//
// Table writes and idle items: the result is registered in the cycle after the item.
// Byte: step, then epsilon closure, one pass per cycle, until the set stops growing;
// end of string: result only. When a string opens, the start state is closed first.
// One item at a time; a stalled result holds the next item back.
// Reset clears the active set and string flags; table entries are undefined until written.
module nfa_regex_matcher #(
    parameter int NUM_STATES = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_addr,
    input  logic [5:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [5:0] s_entry_index,
    input  logic [1:0] s_entry_kind,
    input  logic [7:0] s_entry_char,
    input  logic [6:0] s_entry_first_next,
    input  logic [6:0] s_entry_second_next,
    input  logic [7:0] s_text_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_verdict_valid,
    output logic       m_matched,
    output logic       m_alive
);

    typedef enum logic [1:0] {ST_IDLE, ST_ACT, ST_CLOSE, ST_DONE} state_t;

    state_t     state_reg;
    logic [5:0] start_index_reg;
    logic [5:0] accept_index_reg;
    logic [7:0] byte_reg;
    logic       op_end_reg;
    logic       stepped_reg;
    logic       in_string_reg;
    logic       dead_reg;
    logic       m_valid_reg;
    logic       m_verdict_reg;
    logic       m_matched_reg;
    logic       m_alive_reg;

    nrm_pkg::cell_cmd_t     cmd;
    logic [NUM_STATES-1:0]  active_vec;
    logic [NUM_STATES-1:0]  eps_hit;
    logic [NUM_STATES-1:0]  step_hit;
    logic [NUM_STATES-1:0]  start_hot;
    logic [NUM_STATES-1:0]  wr_hot;
    logic [NUM_STATES-1:0]  eps_vec  [NUM_STATES];
    logic [NUM_STATES-1:0]  step_vec [NUM_STATES];
    logic [NUM_STATES-1:0]  acc_shift;
    logic                   in_go;
    logic                   out_free;
    logic                   is_run;
    logic                   grow;
    logic                   any_active;
    logic                   acc_hit;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_go    = s_valid && s_ready;
    assign is_run   = (s_mode == nrm_pkg::MODE_BYTE) || (s_mode == nrm_pkg::MODE_END);

    always_comb begin
        for (int j = 0; j < NUM_STATES; j++) begin
            eps_hit[j]   = 1'b0;
            step_hit[j]  = 1'b0;
            start_hot[j] = (32'(start_index_reg) == j);
            wr_hot[j]    = in_go && (s_mode == nrm_pkg::MODE_WRITE)
                           && (32'(s_entry_index) == j);
            for (int i = 0; i < NUM_STATES; i++) begin
                eps_hit[j]  = eps_hit[j]  | eps_vec[i][j];
                step_hit[j] = step_hit[j] | step_vec[i][j];
            end
        end
    end

    assign grow       = |(eps_hit & ~active_vec);
    assign any_active = |active_vec;
    assign acc_shift  = active_vec >> accept_index_reg;
    assign acc_hit    = acc_shift[0] && (32'(accept_index_reg) < NUM_STATES);

    always_comb begin
        cmd       = '0;
        cmd.load  = (state_reg == ST_IDLE) && in_go && is_run && !in_string_reg;
        cmd.step  = (state_reg == ST_ACT) && !op_end_reg && !dead_reg;
        cmd.close = (state_reg == ST_CLOSE);
        cmd.clear = (state_reg == ST_DONE) && out_free && op_end_reg;
    end

    for (genvar g = 0; g < NUM_STATES; g++) begin : g_cell
        nrm_cell #(.NUM_STATES(NUM_STATES)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .wr_en     (wr_hot[g]),
            .wr_kind   (s_entry_kind),
            .wr_char   (s_entry_char),
            .wr_first  (s_entry_first_next),
            .wr_second (s_entry_second_next),
            .cmd       (cmd),
            .is_start  (start_hot[g]),
            .eps_hit   (eps_hit[g]),
            .step_hit  (step_hit[g]),
            .text_byte (byte_reg),
            .active    (active_vec[g]),
            .eps_vec   (eps_vec[g]),
            .step_vec  (step_vec[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_index_reg  <= '0;
            accept_index_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                nrm_pkg::REG_START:  start_index_reg  <= cfg_wdata;
                nrm_pkg::REG_ACCEPT: accept_index_reg <= cfg_wdata;
                default:             start_index_reg  <= start_index_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            in_string_reg <= 1'b0;
            dead_reg      <= 1'b0;
            op_end_reg    <= 1'b0;
            stepped_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_verdict_reg <= 1'b0;
            m_matched_reg <= 1'b0;
            m_alive_reg   <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_go) begin
                        byte_reg    <= s_text_byte;
                        op_end_reg  <= (s_mode == nrm_pkg::MODE_END);
                        stepped_reg <= 1'b0;
                        if (is_run) begin
                            if (!in_string_reg) begin
                                in_string_reg <= 1'b1;
                                dead_reg      <= 1'b0;
                                state_reg     <= ST_CLOSE;
                            end else begin
                                state_reg <= ST_ACT;
                            end
                        end else begin
                            m_valid_reg   <= 1'b1;
                            m_verdict_reg <= 1'b0;
                            m_matched_reg <= 1'b0;
                            m_alive_reg   <= any_active;
                        end
                    end
                end
                ST_ACT: begin
                    if (!op_end_reg && !dead_reg) begin
                        stepped_reg <= 1'b1;
                        state_reg   <= ST_CLOSE;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_CLOSE: begin
                    if (!grow) begin
                        if (stepped_reg) begin
                            dead_reg  <= dead_reg | !any_active;
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_ACT;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_verdict_reg <= op_end_reg;
                        m_matched_reg <= op_end_reg && !dead_reg && acc_hit;
                        m_alive_reg   <= any_active;
                        if (op_end_reg) begin
                            in_string_reg <= 1'b0;
                            dead_reg      <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_verdict_valid = m_verdict_reg;
    assign m_matched       = m_matched_reg;
    assign m_alive         = m_alive_reg;

    a_match_alive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_matched |-> m_alive && m_verdict_valid)
        else $error("match reported on an empty set or without a verdict");

    a_dead_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        dead_reg |-> !any_active)
        else $error("dead string holds active states");

    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready)
        else $error("item taken while a string step is in flight");

endmodule
